>>> rtl/txyr_pkg.sv
package txyr_pkg;

    // Field widths
    localparam int NODE_W     = 8;
    localparam int LOCAL_W    = 2;
    localparam int PORT_W     = 3;
    localparam int MSG_W      = 16;
    localparam int RING_W     = 5;
    localparam int BUFW_W     = 11;
    localparam int MPC_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Pipeline shape: divider stages, then route decision, then bubble compare
    localparam int DIV_STAGES   = 8;
    localparam int MSG_STEPS    = MSG_W / DIV_STAGES;
    localparam int COORD_STAGES = DIV_STAGES / 2;
    localparam int COORD_STEPS  = NODE_W / COORD_STAGES;
    localparam int PIPE_STAGES  = DIV_STAGES + 2;
    localparam int CMP_W        = MSG_W + 1;
    localparam int NUM_CRED     = 5;

    // Port codes
    localparam logic [PORT_W-1:0] PORT_MINUS_Y     = 3'd0;
    localparam logic [PORT_W-1:0] PORT_PLUS_X      = 3'd1;
    localparam logic [PORT_W-1:0] PORT_PLUS_Y      = 3'd2;
    localparam logic [PORT_W-1:0] PORT_MINUS_X     = 3'd3;
    localparam logic [PORT_W-1:0] FIRST_LOCAL_PORT = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CREDITS  = 3'd4;

    // Register reset values
    localparam logic [NODE_W-1:0] RST_ROUTER_ID    = 8'd0;
    localparam logic [RING_W-1:0] RST_SIZE_X       = 5'd4;
    localparam logic [RING_W-1:0] RST_SIZE_Y       = 5'd4;
    localparam logic [BUFW_W-1:0] RST_BUFFER_WIDTH = 11'd32;
    localparam logic [MPC_W-1:0]  RST_MAX_CREDITS  = 10'd1;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic [PIPE_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

>>> rtl/txyr_req_if.sv
interface txyr_req_if
    import txyr_pkg::*;
#(
    parameter int CREDIT_WIDTH = 10
);
    logic                    valid;
    logic                    ready;
    logic [NODE_W-1:0]       dest_node;
    logic [LOCAL_W-1:0]      dest_local;
    logic [PORT_W-1:0]       in_port;
    logic [MSG_W-1:0]        message_size;
    logic [CREDIT_WIDTH-1:0] credit_minus_y;
    logic [CREDIT_WIDTH-1:0] credit_plus_x;
    logic [CREDIT_WIDTH-1:0] credit_plus_y;
    logic [CREDIT_WIDTH-1:0] credit_minus_x;
    logic [CREDIT_WIDTH-1:0] credit_local;

    modport source (
        output valid, dest_node, dest_local, in_port, message_size,
               credit_minus_y, credit_plus_x, credit_plus_y, credit_minus_x, credit_local,
        input  ready
    );

    modport sink (
        input  valid, dest_node, dest_local, in_port, message_size,
               credit_minus_y, credit_plus_x, credit_plus_y, credit_minus_x, credit_local,
        output ready
    );
endinterface

>>> rtl/txyr_rsp_if.sv
interface txyr_rsp_if
    import txyr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              blocked;
    logic [PORT_W-1:0] out_port;

    modport source (
        output valid, blocked, out_port,
        input  ready
    );

    modport sink (
        input  valid, blocked, out_port,
        output ready
    );
endinterface

>>> rtl/txyr_div_step.sv
// A few restoring division steps: shift a dividend bit into the remainder,
// subtract the divisor when it fits, shift the quotient bit into the word.
module txyr_div_step #(
    parameter int WORD_W = 8,
    parameter int DIV_W  = 5,
    parameter int STEPS  = 2
) (
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [WORD_W-1:0] i_word,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic [DIV_W-1:0]  o_rem,
    output logic [WORD_W-1:0] o_word
);
    logic [DIV_W-1:0]  rem_q  [0:STEPS];
    logic [WORD_W-1:0] word_q [0:STEPS];
    logic [DIV_W:0]    trial  [0:STEPS-1];

    always_comb begin
        rem_q[0]  = i_rem;
        word_q[0] = i_word;
        for (int s = 0; s < STEPS; s++) begin
            trial[s] = {rem_q[s], word_q[s][WORD_W-1]};
            if (trial[s] >= {1'b0, i_divisor}) begin
                rem_q[s+1]  = DIV_W'(trial[s] - {1'b0, i_divisor});
                word_q[s+1] = {word_q[s][WORD_W-2:0], 1'b1};
            end else begin
                rem_q[s+1]  = trial[s][DIV_W-1:0];
                word_q[s+1] = {word_q[s][WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rem  = rem_q[STEPS];
    assign o_word = word_q[STEPS];
endmodule

>>> rtl/txyr_pipe_ctl.sv
// Valid bits and per-stage load enables; a stage loads when it is empty
// or when the stage after it moves.
module txyr_pipe_ctl
    import txyr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] upstream_vld;
    logic [PIPE_STAGES:0]   stage_ready;

    assign upstream_vld = {r_vld[PIPE_STAGES-2:0], i_in_valid};

    always_comb begin
        stage_ready[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !r_vld[k] || stage_ready[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (stage_ready[k]) begin
                n_vld[k] = upstream_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stage_ready[0];
    assign o_out_valid = r_vld[PIPE_STAGES-1];
    assign o_ctl.en    = stage_ready[PIPE_STAGES-1:0];
    assign o_ctl.vld   = r_vld;
endmodule

>>> rtl/torus_xy_route_with_bubble.sv
// Route computation for packet heads in a 2D folded-torus router.
// i_req carries one head per beat: destination node and local port, arrival
// port, message length in bits and the free credits of the five candidate
// ports. o_rsp returns one beat per head: blocked and out_port (out_port is
// 0 when blocked). Registers are written through i_cfg_we/i_cfg_idx/
// i_cfg_data, by the user only while no head is in flight (not enforced by
// the block); unknown indexes are dropped. Throughput: one head per cycle
// unless o_rsp stalls. The depth comes from the eight stages of the
// radix-4 restoring dividers (two quotient bits per stage): the message
// credit divider runs all eight, while the node coordinate divider spends
// four stages on div/mod by size_x and four on mod by size_y. One stage picks
// the port, the last does the bubble compare and is the output register.
// Reset: all valid bits clear and registers return to their defaults
// (router 0, 4x4 ring, 32-bit credits, reserve of 1 credit).
// Stall: a result waiting on o_rsp holds; upstream stages keep filling
// their empty slots, and i_req.ready drops only once every stage is full.
module torus_xy_route_with_bubble
    import txyr_pkg::*;
#(
    parameter int CREDIT_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    txyr_req_if.sink              i_req,
    txyr_rsp_if.source            o_rsp
);
    localparam int LAST = DIV_STAGES - 1;

    // Configuration registers
    logic [NODE_W-1:0] r_router_id;
    logic [RING_W-1:0] r_size_x;
    logic [RING_W-1:0] r_size_y;
    logic [BUFW_W-1:0] r_buffer_width;
    logic [MPC_W-1:0]  r_max_credits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_router_id    <= RST_ROUTER_ID;
            r_size_x       <= RST_SIZE_X;
            r_size_y       <= RST_SIZE_Y;
            r_buffer_width <= RST_BUFFER_WIDTH;
            r_max_credits  <= RST_MAX_CREDITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROUTER_ID:    r_router_id    <= i_cfg_data[NODE_W-1:0];
                CFG_SIZE_X:       r_size_x       <= i_cfg_data[RING_W-1:0];
                CFG_SIZE_Y:       r_size_y       <= i_cfg_data[RING_W-1:0];
                CFG_BUFFER_WIDTH: r_buffer_width <= i_cfg_data[BUFW_W-1:0];
                CFG_MAX_CREDITS:  r_max_credits  <= i_cfg_data[MPC_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero size or width behaves as one
    logic [RING_W-1:0] sx_eff;
    logic [RING_W-1:0] sy_eff;
    logic [BUFW_W-1:0] bw_eff;

    assign sx_eff = (r_size_x == '0) ? RING_W'(1) : r_size_x;
    assign sy_eff = (r_size_y == '0) ? RING_W'(1) : r_size_y;
    assign bw_eff = (r_buffer_width == '0) ? BUFW_W'(1) : r_buffer_width;

    // Handshake control
    t_pipe_ctl ctl;
    logic      in_ready;
    logic      out_valid;

    txyr_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // Divider stage registers. The dst/rid lanes hold {remainder, word}: the
    // word shifts dividend bits out at the top and quotient bits in below.
    logic [RING_W-1:0]                 r_dst_rem  [0:LAST];
    logic [NODE_W-1:0]                 r_dst_word [0:LAST];
    logic [RING_W-1:0]                 r_rid_rem  [0:LAST];
    logic [NODE_W-1:0]                 r_rid_word [0:LAST];
    logic [BUFW_W-1:0]                 r_msg_rem  [0:LAST];
    logic [MSG_W-1:0]                  r_msg_word [0:LAST];
    logic [RING_W-1:0]                 r_dx       [COORD_STAGES:LAST];
    logic [RING_W-1:0]                 r_rx       [COORD_STAGES:LAST];
    logic [LOCAL_W-1:0]                r_dloc     [0:LAST];
    logic [PORT_W-1:0]                 r_inp      [0:LAST];
    logic [NUM_CRED-1:0][CREDIT_WIDTH-1:0] r_cred [0:LAST];

    logic [NUM_CRED-1:0][CREDIT_WIDTH-1:0] req_cred;

    // Credits indexed by port code, local last
    assign req_cred = {i_req.credit_local, i_req.credit_minus_x, i_req.credit_plus_y,
                       i_req.credit_plus_x, i_req.credit_minus_y};

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [RING_W-1:0] dst_rem_in;
        logic [NODE_W-1:0] dst_word_in;
        logic [RING_W-1:0] rid_rem_in;
        logic [NODE_W-1:0] rid_word_in;
        logic [BUFW_W-1:0] msg_rem_in;
        logic [MSG_W-1:0]  msg_word_in;
        logic [RING_W-1:0] dst_rem_out;
        logic [NODE_W-1:0] dst_word_out;
        logic [RING_W-1:0] rid_rem_out;
        logic [NODE_W-1:0] rid_word_out;
        logic [BUFW_W-1:0] msg_rem_out;
        logic [MSG_W-1:0]  msg_word_out;
        logic [RING_W-1:0] ring_div;
        logic [LOCAL_W-1:0] dloc_in;
        logic [PORT_W-1:0]  inp_in;
        logic [NUM_CRED-1:0][CREDIT_WIDTH-1:0] cred_in;

        if (k == 0) begin : g_head
            assign dst_rem_in  = '0;
            assign dst_word_in = i_req.dest_node;
            assign rid_rem_in  = '0;
            assign rid_word_in = r_router_id;
            assign msg_rem_in  = '0;
            assign msg_word_in = i_req.message_size;
            assign dloc_in     = i_req.dest_local;
            assign inp_in      = i_req.in_port;
            assign cred_in     = req_cred;
        end else begin : g_body
            // At the turn, restart the coordinate lanes on the quotient
            // to reduce the row index modulo size_y
            if (k == COORD_STAGES) begin : g_turn
                assign dst_rem_in = '0;
                assign rid_rem_in = '0;
            end else begin : g_cont
                assign dst_rem_in = r_dst_rem[k-1];
                assign rid_rem_in = r_rid_rem[k-1];
            end
            assign dst_word_in = r_dst_word[k-1];
            assign rid_word_in = r_rid_word[k-1];
            assign msg_rem_in  = r_msg_rem[k-1];
            assign msg_word_in = r_msg_word[k-1];
            assign dloc_in     = r_dloc[k-1];
            assign inp_in      = r_inp[k-1];
            assign cred_in     = r_cred[k-1];
        end

        assign ring_div = (k < COORD_STAGES) ? sx_eff : sy_eff;

        txyr_div_step #(
            .WORD_W (NODE_W),
            .DIV_W  (RING_W),
            .STEPS  (COORD_STEPS)
        ) u_dst (
            .i_rem     (dst_rem_in),
            .i_word    (dst_word_in),
            .i_divisor (ring_div),
            .o_rem     (dst_rem_out),
            .o_word    (dst_word_out)
        );

        txyr_div_step #(
            .WORD_W (NODE_W),
            .DIV_W  (RING_W),
            .STEPS  (COORD_STEPS)
        ) u_rid (
            .i_rem     (rid_rem_in),
            .i_word    (rid_word_in),
            .i_divisor (ring_div),
            .o_rem     (rid_rem_out),
            .o_word    (rid_word_out)
        );

        txyr_div_step #(
            .WORD_W (MSG_W),
            .DIV_W  (BUFW_W),
            .STEPS  (MSG_STEPS)
        ) u_msg (
            .i_rem     (msg_rem_in),
            .i_word    (msg_word_in),
            .i_divisor (bw_eff),
            .o_rem     (msg_rem_out),
            .o_word    (msg_word_out)
        );

        always_ff @(posedge i_clk) begin
            if (ctl.en[k]) begin
                r_dst_rem[k]  <= dst_rem_out;
                r_dst_word[k] <= dst_word_out;
                r_rid_rem[k]  <= rid_rem_out;
                r_rid_word[k] <= rid_word_out;
                r_msg_rem[k]  <= msg_rem_out;
                r_msg_word[k] <= msg_word_out;
                r_dloc[k]     <= dloc_in;
                r_inp[k]      <= inp_in;
                r_cred[k]     <= cred_in;
            end
        end

        // Capture X coordinates at the turn, then carry them along
        if (k == COORD_STAGES) begin : g_cap
            always_ff @(posedge i_clk) begin
                if (ctl.en[k]) begin
                    r_dx[k] <= r_dst_rem[k-1];
                    r_rx[k] <= r_rid_rem[k-1];
                end
            end
        end else if (k > COORD_STAGES) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (ctl.en[k]) begin
                    r_dx[k] <= r_dx[k-1];
                    r_rx[k] <= r_rx[k-1];
                end
            end
        end
    end

    // Distance going the plus way from a_pos to b_pos on a ring; both below size
    function automatic logic [RING_W-1:0] ring_fwd(
        input logic [RING_W-1:0] a_pos,
        input logic [RING_W-1:0] b_pos,
        input logic [RING_W-1:0] size
    );
        logic [RING_W:0] wrap;
        wrap = {1'b0, b_pos} + {1'b0, size} - {1'b0, a_pos};
        if (b_pos >= a_pos) begin
            return b_pos - a_pos;
        end
        return wrap[RING_W-1:0];
    endfunction

    // Route decision stage
    logic [RING_W-1:0]       dx, rx, dy, ry;
    logic [RING_W-1:0]       plus_x, minus_x, plus_y, minus_y;
    logic [PORT_W-1:0]       route_port;
    logic                    route_check;
    logic [CREDIT_WIDTH-1:0] route_avail;
    logic [CMP_W-1:0]        route_need;

    logic [PORT_W-1:0]       r_route_port;
    logic                    r_route_check;
    logic [CREDIT_WIDTH-1:0] r_route_avail;
    logic [CMP_W-1:0]        r_route_need;

    assign dx = r_dx[LAST];
    assign rx = r_rx[LAST];
    assign dy = r_dst_rem[LAST];
    assign ry = r_rid_rem[LAST];

    always_comb begin
        plus_x  = ring_fwd(rx, dx, sx_eff);
        minus_x = ring_fwd(dx, rx, sx_eff);
        plus_y  = ring_fwd(ry, dy, sy_eff);
        minus_y = ring_fwd(dy, ry, sy_eff);

        // X first, then Y; a tie goes the plus way
        if (dx != rx) begin
            route_port = (minus_x < plus_x) ? PORT_MINUS_X : PORT_PLUS_X;
        end else if (dy != ry) begin
            route_port = (minus_y < plus_y) ? PORT_MINUS_Y : PORT_PLUS_Y;
        end else begin
            route_port = FIRST_LOCAL_PORT + PORT_W'(r_dloc[LAST]);
        end

        // Bubble rule on injection and on the X to Y turn
        route_check = (r_inp[LAST] >= FIRST_LOCAL_PORT) ||
                      ((r_inp[LAST] == PORT_PLUS_X || r_inp[LAST] == PORT_MINUS_X) &&
                       (route_port == PORT_MINUS_Y || route_port == PORT_PLUS_Y));

        case (route_port)
            PORT_MINUS_Y: route_avail = r_cred[LAST][PORT_MINUS_Y];
            PORT_PLUS_X:  route_avail = r_cred[LAST][PORT_PLUS_X];
            PORT_PLUS_Y:  route_avail = r_cred[LAST][PORT_PLUS_Y];
            PORT_MINUS_X: route_avail = r_cred[LAST][PORT_MINUS_X];
            default:      route_avail = r_cred[LAST][FIRST_LOCAL_PORT];
        endcase

        // Round the credit count up on a nonzero remainder
        route_need = {1'b0, r_msg_word[LAST]} + CMP_W'(r_msg_rem[LAST] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[DIV_STAGES]) begin
            r_route_port  <= route_port;
            r_route_check <= route_check;
            r_route_avail <= route_avail;
            r_route_need  <= route_need;
        end
    end

    // Bubble compare and output register
    logic              route_blocked;
    logic              r_blocked;
    logic [PORT_W-1:0] r_out_port;

    assign route_blocked = r_route_check &&
                           (CMP_W'(r_route_avail) < r_route_need + CMP_W'(r_max_credits));

    always_ff @(posedge i_clk) begin
        if (ctl.en[DIV_STAGES+1]) begin
            r_blocked  <= route_blocked;
            r_out_port <= route_blocked ? PORT_MINUS_Y : r_route_port;
        end
    end

    assign o_rsp.blocked  = r_blocked;
    assign o_rsp.out_port = r_out_port;

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.ready |-> i_req.ready)
        else $error("input stalled while output is taken");

    a_accept_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> ctl.vld[0])
        else $error("accepted beat lost at first stage");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && !ctl.vld[DIV_STAGES]) |=> !o_rsp.valid)
        else $error("result repeated after it was taken");

    a_unchecked_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.vld[DIV_STAGES] && ctl.en[DIV_STAGES+1] && !r_route_check) |=> !o_rsp.blocked)
        else $error("route blocked without bubble check");
`endif
endmodule

>>> tb/sv/tb_torus_xy_route_with_bubble.sv
module tb_torus_xy_route_with_bubble;
    import txyr_pkg::*;

    localparam int CRED_W      = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    // One head flit as offered on the request channel
    typedef struct packed {
        logic [NODE_W-1:0]  dest_node;
        logic [LOCAL_W-1:0] dest_local;
        logic [PORT_W-1:0]  in_port;
        logic [MSG_W-1:0]   message_size;
        logic [CRED_W-1:0]  credit_minus_y;
        logic [CRED_W-1:0]  credit_plus_x;
        logic [CRED_W-1:0]  credit_plus_y;
        logic [CRED_W-1:0]  credit_minus_x;
        logic [CRED_W-1:0]  credit_local;
    } head_t;

    // One routing decision as returned on the response channel
    typedef struct packed {
        logic              blocked;
        logic [PORT_W-1:0] out_port;
    } route_t;

    // Keeps a private copy of the registers, predicts the route of every
    // accepted head and checks the returned routes in order.
    class route_scoreboard;
        logic [NODE_W-1:0] router_id;
        logic [RING_W-1:0] size_x;
        logic [RING_W-1:0] size_y;
        logic [BUFW_W-1:0] buffer_width;
        logic [MPC_W-1:0]  max_credits;
        route_t            pending_routes[$];
        int unsigned       errors;

        function new();
            router_id    = RST_ROUTER_ID;
            size_x       = RST_SIZE_X;
            size_y       = RST_SIZE_Y;
            buffer_width = RST_BUFFER_WIDTH;
            max_credits  = RST_MAX_CREDITS;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROUTER_ID:    router_id    = data[NODE_W-1:0];
                CFG_SIZE_X:       size_x       = data[RING_W-1:0];
                CFG_SIZE_Y:       size_y       = data[RING_W-1:0];
                CFG_BUFFER_WIDTH: buffer_width = data[BUFW_W-1:0];
                CFG_MAX_CREDITS:  max_credits  = data[MPC_W-1:0];
                default: ;
            endcase
        endfunction

        function route_t predict_route(head_t h);
            int unsigned sx, sy, bw, rx, ry, dx, dy, to_minus, to_plus, avail, need;
            logic [PORT_W-1:0] port;
            bit                check;
            route_t            r;
            // zero sizes and widths behave as one
            sx = (size_x == 0) ? 1 : size_x;
            sy = (size_y == 0) ? 1 : size_y;
            bw = (buffer_width == 0) ? 1 : buffer_width;
            rx = router_id % sx;
            ry = (router_id / sx) % sy;
            dx = h.dest_node % sx;
            dy = (h.dest_node / sx) % sy;
            if (dx != rx) begin
                // correct X first, shorter way round, tie goes to +X
                to_minus = (rx + sx - dx) % sx;
                to_plus  = (dx + sx - rx) % sx;
                port = (to_minus < to_plus) ? PORT_MINUS_X : PORT_PLUS_X;
            end else if (dy != ry) begin
                to_minus = (ry + sy - dy) % sy;
                to_plus  = (dy + sy - ry) % sy;
                port = (to_minus < to_plus) ? PORT_MINUS_Y : PORT_PLUS_Y;
            end else begin
                port = FIRST_LOCAL_PORT + PORT_W'(h.dest_local);
            end
            // bubble rule on injection and on the X-to-Y turn
            check = (h.in_port >= FIRST_LOCAL_PORT) ||
                    ((h.in_port == PORT_PLUS_X || h.in_port == PORT_MINUS_X) &&
                     (port == PORT_MINUS_Y || port == PORT_PLUS_Y));
            case (port)
                PORT_MINUS_Y: avail = h.credit_minus_y;
                PORT_PLUS_X:  avail = h.credit_plus_x;
                PORT_PLUS_Y:  avail = h.credit_plus_y;
                PORT_MINUS_X: avail = h.credit_minus_x;
                default:      avail = h.credit_local;
            endcase
            need = (h.message_size + bw - 1) / bw;
            r.blocked  = check && (avail < need + max_credits);
            r.out_port = r.blocked ? '0 : port;
            return r;
        endfunction

        function void note_head(head_t h);
            pending_routes.push_back(predict_route(h));
        endfunction

        function void check_route(logic blocked, logic [PORT_W-1:0] out_port);
            route_t want;
            if (pending_routes.size() == 0) begin
                $error("route: none pending, got blocked=%0d out_port=%0d", blocked, out_port);
                errors++;
                return;
            end
            want = pending_routes.pop_front();
            if (blocked !== want.blocked) begin
                $error("blocked: expected %0d, actual %0d", want.blocked, blocked);
                errors++;
            end
            if (out_port !== want.out_port) begin
                $error("out_port: expected %0d, actual %0d", want.out_port, out_port);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_routes.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    txyr_req_if #(.CREDIT_WIDTH(CRED_W)) req_bus ();
    txyr_rsp_if                          rsp_bus ();

    route_scoreboard sb = new();

    // Idle percentages per side; zero gives a stretch of back-to-back beats
    int unsigned req_idle_pct = 25;
    int unsigned rsp_idle_pct = 25;
    // Set by the stimulus to make the receiver hold off for a long stretch
    bit          hold_trigger = 0;
    int unsigned cycle_count  = 0;

    torus_xy_route_with_bubble #(
        .CREDIT_WIDTH(CRED_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Bound the run; a hang anywhere ends here as a failure
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[torus_xy_route_with_bubble] ERROR");
        $finish;
    end

    // Receiver: drive ready at the falling edge. On a trigger, hold ready low
    // through the hold_left countdown while the sender keeps offering, so the pipe
    // fills up and the block has to drop its input ready.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger) begin
                hold_left    = HOLD_CYCLES;
                hold_trigger = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    // Check every result beat at the rising edge it is taken on
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_route(rsp_bus.blocked, rsp_bus.out_port);
    end

    // Offer one head, with random idle cycles first; return at the falling
    // edge after the beat is taken, leaving valid as it is so that a
    // following head goes out back to back.
    task automatic send_head(input head_t h);
        while ($urandom_range(99) < req_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.dest_node      <= h.dest_node;
        req_bus.dest_local     <= h.dest_local;
        req_bus.in_port        <= h.in_port;
        req_bus.message_size   <= h.message_size;
        req_bus.credit_minus_y <= h.credit_minus_y;
        req_bus.credit_plus_x  <= h.credit_plus_x;
        req_bus.credit_plus_y  <= h.credit_plus_y;
        req_bus.credit_minus_x <= h.credit_minus_x;
        req_bus.credit_local   <= h.credit_local;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_head(h);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every predicted route to come back
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Write all five registers back to back; only called with nothing in flight
    task automatic apply_setting(input int unsigned rid, input int unsigned sx,
                                 input int unsigned sy, input int unsigned bw,
                                 input int unsigned mpc);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idxs[5];
        vals = '{CFG_DATA_W'(rid), CFG_DATA_W'(sx), CFG_DATA_W'(sy),
                 CFG_DATA_W'(bw), CFG_DATA_W'(mpc)};
        idxs = '{CFG_ROUTER_ID, CFG_SIZE_X, CFG_SIZE_Y, CFG_BUFFER_WIDTH, CFG_MAX_CREDITS};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            sb.write_reg(idxs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Credit value within two of the bubble threshold half the time, random otherwise
    function automatic logic [CRED_W-1:0] pick_credit(input int unsigned thr);
        int v;
        if ($urandom_range(1) == 0)
            return CRED_W'($urandom);
        v = int'(thr) - 2 + int'($urandom_range(4));
        if (v < 0)
            v = 0;
        if (v > (1 << CRED_W) - 1)
            v = (1 << CRED_W) - 1;
        return CRED_W'(v);
    endfunction

    // Mostly destinations inside the torus, and half of the message sizes within
    // eight credits, so both sides of the bubble compare get hit; the rest spans
    // the whole field range.
    function automatic head_t rand_head();
        head_t       h;
        int unsigned sx, sy, nodes, bw, top, thr;
        sx    = (sb.size_x == 0) ? 1 : sb.size_x;
        sy    = (sb.size_y == 0) ? 1 : sb.size_y;
        bw    = (sb.buffer_width == 0) ? 1 : sb.buffer_width;
        nodes = sx * sy;
        if ($urandom_range(99) < 75 && nodes <= 256)
            h.dest_node = NODE_W'($urandom_range(nodes - 1));
        else
            h.dest_node = NODE_W'($urandom);
        h.dest_local = LOCAL_W'($urandom);
        h.in_port    = PORT_W'($urandom);
        top = bw * 8;
        if (top > 65535)
            top = 65535;
        if ($urandom_range(99) < 50)
            h.message_size = MSG_W'($urandom);
        else
            h.message_size = MSG_W'($urandom_range(top));
        thr = (h.message_size + bw - 1) / bw + sb.max_credits;
        h.credit_minus_y = pick_credit(thr);
        h.credit_plus_x  = pick_credit(thr);
        h.credit_plus_y  = pick_credit(thr);
        h.credit_minus_x = pick_credit(thr);
        h.credit_local   = pick_credit(thr);
        return h;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count) send_head(rand_head());
        drain();
    endtask

    initial begin
        head_t directed[$];
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        req_bus.valid          = 1'b0;
        req_bus.dest_node      = '0;
        req_bus.dest_local     = '0;
        req_bus.in_port        = '0;
        req_bus.message_size   = '0;
        req_bus.credit_minus_y = '0;
        req_bus.credit_plus_x  = '0;
        req_bus.credit_plus_y  = '0;
        req_bus.credit_minus_x = '0;
        req_bus.credit_local   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed heads at the reset setting: router 0 on a 4x4 torus,
        // 32 bits per credit, reserve of one credit. Fields are
        // dest, local, in_port, size, -Y, +X, +Y, -X, local credits.
        // home node on local ports 0 to 2, injected: pass, short, oversize
        directed.push_back('{8'd0, 2'd0, 3'd4, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd2});
        directed.push_back('{8'd0, 2'd1, 3'd5, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1});
        directed.push_back('{8'd0, 2'd2, 3'd6, 16'hFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF});
        // transit from a Y port: no bubble check even with zero credit
        directed.push_back('{8'd0, 2'd3, 3'd0, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        // X moves: +X, -X, tie goes to +X, no check when staying on X
        directed.push_back('{8'd1, 2'd0, 3'd3, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        directed.push_back('{8'd3, 2'd0, 3'd1, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        directed.push_back('{8'd2, 2'd0, 3'd0, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        // X-to-Y turn: +Y passes on the threshold, -Y refused one below it
        directed.push_back('{8'd4, 2'd0, 3'd1, 16'd32, 10'd0, 10'd0, 10'd2, 10'd0, 10'd0});
        directed.push_back('{8'd12, 2'd0, 3'd3, 16'd32, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0});
        // Y tie goes to +Y; straight Y transit is not checked
        directed.push_back('{8'd8, 2'd0, 3'd2, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        // empty message needs no credit, only the reserve
        directed.push_back('{8'd4, 2'd0, 3'd4, 16'd0, 10'd0, 10'd0, 10'd1, 10'd0, 10'd0});
        directed.push_back('{8'd4, 2'd0, 3'd4, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        // highest node index: Y coordinate beyond the ring, largest message
        directed.push_back('{8'd255, 2'd3, 3'd7, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF,
                             10'h3FF, 10'h3FF});
        // one bit over a credit rounds up to two
        directed.push_back('{8'd15, 2'd0, 3'd5, 16'd33, 10'd0, 10'd0, 10'd0, 10'd3, 10'd0});
        directed.push_back('{8'd15, 2'd0, 3'd5, 16'd33, 10'd0, 10'd0, 10'd0, 10'd2, 10'd0});
        // Y beyond the ring folds back onto the home node, then three mixed heads
        directed.push_back('{8'd16, 2'd2, 3'd1, 16'd32, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        directed.push_back('{8'd128, 2'd3, 3'd6, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF});
        directed.push_back('{8'd5, 2'd1, 3'd2, 16'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        directed.push_back('{8'd12, 2'd0, 3'd3, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF,
                             10'h3FF, 10'h3FF});
        directed.push_back('{8'd13, 2'd0, 3'd0, 16'hFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        foreach (directed[k])
            send_head(directed[k]);
        run_random(100);

        // Largest setting, with a long receiver hold-off to fill the pipe
        apply_setting(255, 16, 16, 1024, 1023);
        hold_trigger = 1;
        run_random(115);

        // Smallest setting: a single-node torus, one bit per credit
        apply_setting(0, 1, 1, 1, 0);
        run_random(115);

        // Zero ring sizes and zero buffer width behave as one
        apply_setting(37, 0, 0, 0, 0);
        run_random(115);

        for (int p = 0; p < 7; p++) begin
            apply_setting($urandom_range(255), $urandom_range(1, 16), $urandom_range(1, 16),
                          $urandom_range(1, 1024),
                          ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(8));
            // one phase runs with no idling on either side, one with a hold-off
            req_idle_pct = (p == 2) ? 0 : 25;
            rsp_idle_pct = (p == 2) ? 0 : 25;
            if (p == 4)
                hold_trigger = 1;
            run_random(100);
        end

        // Let the pipe settle so a stray extra beat still gets caught
        repeat (PIPE_STAGES + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[torus_xy_route_with_bubble] OK");
        else
            $display("[torus_xy_route_with_bubble] ERROR");
        $finish;
    end

endmodule
